>>> hw/rtl/open_loop_foc_pwm_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the open-loop FOC PWM generator
// Shared property forms used by the checks at the end of the core module.
// ----------------------------------------------------------------------------
`ifndef OPEN_LOOP_FOC_PWM_GENERATOR_CORE_DEFINES_SVH
`define OPEN_LOOP_FOC_PWM_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFPG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OFPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ofpg_pkg.sv
// ----------------------------------------------------------------------------
// ofpg_pkg
// Constants, register map and shared types of the open-loop FOC PWM generator.
// ----------------------------------------------------------------------------
package ofpg_pkg;

    // Electrical angle resolution: the angle keeps only its top bits.
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam logic [31:0] ANGLE_MASK =
        ~((32'h1 << (32 - SINE_TABLE_BITS)) - 32'h1);
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Odd polynomial for one quarter of a sine wave in Q16; the sine limit is Q15.
    localparam logic [16:0] POLY_A = 17'd102944;
    localparam logic [15:0] POLY_B = 16'd42048;
    localparam logic [15:0] POLY_C = 16'd4640;
    localparam logic [16:0] QUARTER_FULL = 17'd65536;
    localparam logic [14:0] SINE_MAX = 15'd32767;

    // sqrt(3) in Q15.
    localparam logic [15:0] SQRT3_Q15 = 16'd56756;

    // Duty numerators are Q30 and scaled by six.
    localparam logic signed [34:0] DUTY_HALF = 35'sh0_C000_0000;
    localparam logic signed [34:0] DUTY_FULL = 35'sh1_8000_0000;

    // floor(q / 6) = (q * RECIP_SIX) >> RECIP_SIX_SHIFT for q below 2^19.
    localparam logic [18:0] RECIP_SIX = 19'd349526;
    localparam int unsigned RECIP_SIX_SHIFT = 21;
    // floor(v / 3) = (v * RECIP_THREE) >> RECIP_THREE_SHIFT for v below 2^17.
    localparam logic [15:0] RECIP_THREE = 16'd43691;
    localparam int unsigned RECIP_THREE_SHIFT = 17;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SUPPLY           = 3'd0,
        CFG_POLE_PAIRS       = 3'd1,
        CFG_ZERO_OFFSET      = 3'd2,
        CFG_PWM_PERIOD       = 3'd3,
        CFG_MAX_INTERVAL     = 3'd4,
        CFG_DEFAULT_INTERVAL = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] supply;
        logic [6:0]  pole_pairs;
        logic [31:0] zero_offset;
        logic [15:0] pwm_period;
        logic [23:0] max_interval;
        logic [23:0] default_interval;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        supply:           16'd12000,
        pole_pairs:       7'd11,
        zero_offset:      32'd0,
        pwm_period:       16'd4200,
        max_interval:     24'd500000,
        default_interval: 24'd1000
    };

endpackage

>>> hw/rtl/ofpg_cfg.sv
// ----------------------------------------------------------------------------
// ofpg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ofpg_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ofpg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ofpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ofpg_pkg::t_cfg                     o_cfg
);

    ofpg_pkg::t_cfg r_cfg;
    ofpg_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (ofpg_pkg::t_cfg_index'(i_cfg_index))
                ofpg_pkg::CFG_SUPPLY:           n_cfg.supply = i_cfg_data[15:0];
                ofpg_pkg::CFG_POLE_PAIRS:       n_cfg.pole_pairs = i_cfg_data[6:0];
                ofpg_pkg::CFG_ZERO_OFFSET:      n_cfg.zero_offset = i_cfg_data[31:0];
                ofpg_pkg::CFG_PWM_PERIOD:       n_cfg.pwm_period = i_cfg_data[15:0];
                ofpg_pkg::CFG_MAX_INTERVAL:     n_cfg.max_interval = i_cfg_data[23:0];
                ofpg_pkg::CFG_DEFAULT_INTERVAL: n_cfg.default_interval = i_cfg_data[23:0];
                default: begin
                    // Writes to unmapped indexes are dropped.
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ofpg_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/ofpg_mul.sv
// ----------------------------------------------------------------------------
// ofpg_mul
// Shared unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module ofpg_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;
    logic [63:0] n_prod;

    assign n_prod = {32'd0, i_a} * {32'd0, i_b};

    // The product holds while no new operation is issued.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/open_loop_foc_pwm_generator_core.sv
// ----------------------------------------------------------------------------
// open_loop_foc_pwm_generator_core
// Open-loop sinusoidal PWM: advances a shaft angle per control tick and
// produces three PWM compare values plus the quadrature drive voltage.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick and yields exactly one output
// transfer. All multiplications share one 32 x 32 multiplier under a
// sequencer, so the input stalls from a tick's transfer until its result
// is loaded, and a new tick is taken only in idle. The finished result
// sits in an output register, so the next tick can start while the
// previous result is still stalled; only the final load of a result waits
// for that register to empty. There is no clearing pass after reset.
// Configuration should be written only while the block is idle.
module open_loop_foc_pwm_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [31:0]                        i_timestamp_us,
    input  logic signed [31:0]                 i_target_speed,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [15:0]                        o_compare_phase_a,
    output logic [15:0]                        o_compare_phase_b,
    output logic [15:0]                        o_compare_phase_c,
    output logic [14:0]                        o_drive_millivolts,
    input  logic                               i_cfg_wr_en,
    input  logic [ofpg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ofpg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

`include "open_loop_foc_pwm_generator_core_defines.svh"

    typedef enum logic [22:0] {
        S_IDLE  = 23'd1 << 0,
        S_DT    = 23'd1 << 1,
        S_PHASE = 23'd1 << 2,
        S_EMUL  = 23'd1 << 3,
        S_ANGLE = 23'd1 << 4,
        S_FOLD  = 23'd1 << 5,
        S_Z2    = 23'd1 << 6,
        S_T     = 23'd1 << 7,
        S_TSUB  = 23'd1 << 8,
        S_UMUL  = 23'd1 << 9,
        S_USUB  = 23'd1 << 10,
        S_YMUL  = 23'd1 << 11,
        S_Y     = 23'd1 << 12,
        S_RMUL  = 23'd1 << 13,
        S_RC    = 23'd1 << 14,
        S_NUM   = 23'd1 << 15,
        S_NHI   = 23'd1 << 16,
        S_NLO   = 23'd1 << 17,
        S_Q     = 23'd1 << 18,
        S_DIV   = 23'd1 << 19,
        S_CMP   = 23'd1 << 20,
        S_DRV   = 23'd1 << 21,
        S_OUT   = 23'd1 << 22
    } t_state;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } t_phase_sel;

    ofpg_pkg::t_cfg cfg;

    ofpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    ofpg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Control state
    t_state      r_state, n_state;
    logic [31:0] r_last, n_last;
    logic [31:0] r_phase, n_phase;
    logic        r_cos, n_cos;
    t_phase_sel  r_ph, n_ph;
    logic        r_out_valid, n_out_valid;

    // Work registers
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_speed, n_speed;
    logic [31:0]        r_angle, n_angle;
    logic [16:0]        r_z, n_z;
    logic               r_neg, n_neg;
    logic [16:0]        r_z2, n_z2;
    logic [15:0]        r_t, n_t;
    logic [16:0]        r_u, n_u;
    logic signed [15:0] r_sin, n_sin;
    logic signed [15:0] r_cosv, n_cosv;
    logic signed [31:0] r_rc, n_rc;
    logic [32:0]        r_n, n_n;
    logic [32:0]        r_hi, n_hi;
    logic [18:0]        r_q, n_q;
    logic [15:0]        r_cmp_a, n_cmp_a;
    logic [15:0]        r_cmp_b, n_cmp_b;
    logic [15:0]        r_cmp_c, n_cmp_c;

    // Output register
    logic [15:0] r_out_a, n_out_a;
    logic [15:0] r_out_b, n_out_b;
    logic [15:0] r_out_c, n_out_c;
    logic [14:0] r_out_drv, n_out_drv;

    // Combinational helpers
    logic               in_xfer;
    logic               out_free;
    logic [31:0]        dt;
    logic               dt_bad;
    logic [23:0]        dt_eff;
    logic [31:0]        fold_angle;
    logic [15:0]        fold_frac;
    logic [16:0]        fold_z;
    logic [17:0]        y_round;
    logic [16:0]        y_half;
    logic [14:0]        y_mag;
    logic signed [15:0] y_val;
    logic [14:0]        cos_mag;
    logic signed [34:0] sin_ext;
    logic signed [34:0] rc_ext;
    logic signed [34:0] num_raw;
    logic [32:0]        num_clamp;
    logic [48:0]        scaled;
    logic [15:0]        cmp_val;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Tick interval, replaced by the default when zero, negative or too long.
    assign dt     = r_now - r_last;
    assign dt_bad = (dt == 32'd0) || dt[31] || (dt > {8'd0, cfg.max_interval});
    assign dt_eff = dt_bad ? cfg.default_interval : dt[23:0];

    // Quadrant fold; the second pass of the polynomial evaluates the cosine.
    assign fold_angle = r_cos ? (r_angle + ofpg_pkg::QUARTER_TURN) : r_angle;
    assign fold_frac  = fold_angle[29:14];
    assign fold_z     = fold_angle[30] ? (ofpg_pkg::QUARTER_FULL - {1'b0, fold_frac})
                                       : {1'b0, fold_frac};

    // Round the Q16 polynomial result to Q15 and saturate at full scale.
    assign y_round = {1'b0, prod[32:16]} + 18'd1;
    assign y_half  = y_round[17:1];
    assign y_mag   = (y_half > {2'd0, ofpg_pkg::SINE_MAX}) ? ofpg_pkg::SINE_MAX
                                                          : y_half[14:0];
    assign y_val   = r_neg ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});

    assign cos_mag = r_cosv[15] ? 15'(-r_cosv) : r_cosv[14:0];

    assign sin_ext = 35'(r_sin);
    assign rc_ext  = 35'(r_rc);

    always_comb begin
        unique case (r_ph)
            PH_A:    num_raw = ofpg_pkg::DUTY_HALF - (sin_ext <<< 16);
            PH_B:    num_raw = ofpg_pkg::DUTY_HALF + rc_ext + (sin_ext <<< 15);
            PH_C:    num_raw = ofpg_pkg::DUTY_HALF - rc_ext + (sin_ext <<< 15);
            default: num_raw = ofpg_pkg::DUTY_HALF;
        endcase
    end

    always_comb begin
        priority if (num_raw[34]) begin
            num_clamp = 33'd0;
        end else if (num_raw > ofpg_pkg::DUTY_FULL) begin
            num_clamp = ofpg_pkg::DUTY_FULL[32:0];
        end else begin
            num_clamp = num_raw[32:0];
        end
    end

    // Numerator times period, recombined from its upper 17-bit and lower 16-bit parts.
    assign scaled  = {r_hi, 16'd0} + {17'd0, prod[31:0]};
    assign cmp_val = (cfg.supply == 16'd0) ? 16'd0
                   : prod[ofpg_pkg::RECIP_SIX_SHIFT +: 16];

    // Operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        unique case (r_state)
            S_DT: begin
                mul_a = r_speed;
                mul_b = {8'd0, dt_eff};
            end
            S_EMUL: begin
                mul_a = r_phase;
                mul_b = {25'd0, cfg.pole_pairs};
            end
            S_Z2: begin
                mul_a = {15'd0, r_z};
                mul_b = {15'd0, r_z};
            end
            S_T: begin
                mul_a = {15'd0, prod[32:16]};
                mul_b = {16'd0, ofpg_pkg::POLY_C};
            end
            S_UMUL: begin
                mul_a = {15'd0, r_z2};
                mul_b = {16'd0, r_t};
            end
            S_YMUL: begin
                mul_a = {15'd0, r_z};
                mul_b = {15'd0, r_u};
            end
            S_RMUL: begin
                mul_a = {16'd0, ofpg_pkg::SQRT3_Q15};
                mul_b = {17'd0, cos_mag};
            end
            S_NHI: begin
                mul_a = {15'd0, r_n[32:16]};
                mul_b = {16'd0, cfg.pwm_period};
            end
            S_NLO: begin
                mul_a = {16'd0, r_n[15:0]};
                mul_b = {16'd0, cfg.pwm_period};
            end
            S_DIV: begin
                mul_a = {13'd0, r_q};
                mul_b = {13'd0, ofpg_pkg::RECIP_SIX};
            end
            S_DRV: begin
                mul_a = {16'd0, cfg.supply};
                mul_b = {16'd0, ofpg_pkg::RECIP_THREE};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_phase     = r_phase;
        n_cos       = r_cos;
        n_ph        = r_ph;
        n_out_valid = r_out_valid;
        n_now       = r_now;
        n_speed     = r_speed;
        n_angle     = r_angle;
        n_z         = r_z;
        n_neg       = r_neg;
        n_z2        = r_z2;
        n_t         = r_t;
        n_u         = r_u;
        n_sin       = r_sin;
        n_cosv      = r_cosv;
        n_rc        = r_rc;
        n_n         = r_n;
        n_hi        = r_hi;
        n_q         = r_q;
        n_cmp_a     = r_cmp_a;
        n_cmp_b     = r_cmp_b;
        n_cmp_c     = r_cmp_c;
        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        n_out_c     = r_out_c;
        n_out_drv   = r_out_drv;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_now   = i_timestamp_us;
                    n_speed = $unsigned(i_target_speed);
                    n_state = S_DT;
                end
            end
            S_DT: begin
                n_last  = r_now;
                n_state = S_PHASE;
            end
            S_PHASE: begin
                n_phase = r_phase + prod[31:0];
                n_state = S_EMUL;
            end
            S_EMUL: begin
                n_state = S_ANGLE;
            end
            S_ANGLE: begin
                n_angle = (prod[31:0] + cfg.zero_offset) & ofpg_pkg::ANGLE_MASK;
                n_cos   = 1'b0;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_z     = fold_z;
                n_neg   = fold_angle[31];
                n_state = S_Z2;
            end
            S_Z2: begin
                n_state = S_T;
            end
            S_T: begin
                n_z2    = prod[32:16];
                n_state = S_TSUB;
            end
            S_TSUB: begin
                n_t     = ofpg_pkg::POLY_B - prod[31:16];
                n_state = S_UMUL;
            end
            S_UMUL: begin
                n_state = S_USUB;
            end
            S_USUB: begin
                n_u     = ofpg_pkg::POLY_A - prod[32:16];
                n_state = S_YMUL;
            end
            S_YMUL: begin
                n_state = S_Y;
            end
            S_Y: begin
                if (r_cos) begin
                    n_cosv  = y_val;
                    n_state = S_RMUL;
                end else begin
                    n_sin   = y_val;
                    n_cos   = 1'b1;
                    n_state = S_FOLD;
                end
            end
            S_RMUL: begin
                n_state = S_RC;
            end
            S_RC: begin
                n_rc    = r_cosv[15] ? -$signed(prod[31:0]) : $signed(prod[31:0]);
                n_ph    = PH_A;
                n_state = S_NUM;
            end
            S_NUM: begin
                n_n     = num_clamp;
                n_state = S_NHI;
            end
            S_NHI: begin
                n_state = S_NLO;
            end
            S_NLO: begin
                n_hi    = prod[32:0];
                n_state = S_Q;
            end
            S_Q: begin
                n_q     = scaled[48:30];
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                unique case (r_ph)
                    PH_A: begin
                        n_cmp_a = cmp_val;
                        n_ph    = PH_B;
                        n_state = S_NUM;
                    end
                    PH_B: begin
                        n_cmp_b = cmp_val;
                        n_ph    = PH_C;
                        n_state = S_NUM;
                    end
                    default: begin
                        n_cmp_c = cmp_val;
                        n_state = S_DRV;
                    end
                endcase
            end
            S_DRV: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // Wait here until the previous result has been transferred.
                if (out_free) begin
                    n_out_a     = r_cmp_a;
                    n_out_b     = r_cmp_b;
                    n_out_c     = r_cmp_c;
                    n_out_drv   = prod[ofpg_pkg::RECIP_THREE_SHIFT +: 15];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 32'd0;
            r_phase     <= 32'd0;
            r_cos       <= 1'b0;
            r_ph        <= PH_A;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_phase     <= n_phase;
            r_cos       <= n_cos;
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_speed   <= n_speed;
        r_angle   <= n_angle;
        r_z       <= n_z;
        r_neg     <= n_neg;
        r_z2      <= n_z2;
        r_t       <= n_t;
        r_u       <= n_u;
        r_sin     <= n_sin;
        r_cosv    <= n_cosv;
        r_rc      <= n_rc;
        r_n       <= n_n;
        r_hi      <= n_hi;
        r_q       <= n_q;
        r_cmp_a   <= n_cmp_a;
        r_cmp_b   <= n_cmp_b;
        r_cmp_c   <= n_cmp_c;
        r_out_a   <= n_out_a;
        r_out_b   <= n_out_b;
        r_out_c   <= n_out_c;
        r_out_drv <= n_out_drv;
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_compare_phase_a  = r_out_a;
    assign o_compare_phase_b  = r_out_b;
    assign o_compare_phase_c  = r_out_c;
    assign o_drive_millivolts = r_out_drv;

    `OFPG_ASSERT_NEXT(a_xfer_starts_tick, i_clk, i_rst_n, in_xfer, (r_state == S_DT), "input transfer did not start the tick sequence")
    `OFPG_ASSERT_SAME(a_result_from_out_state, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_OUT), "result appeared outside the output load step")
    `OFPG_ASSERT_SAME(a_compare_in_period, i_clk, i_rst_n, r_out_valid, ((r_out_a <= cfg.pwm_period) && (r_out_b <= cfg.pwm_period) && (r_out_c <= cfg.pwm_period)), "compare value beyond PWM period")
    `OFPG_ASSERT_SAME(a_fold_in_quarter, i_clk, i_rst_n, (r_state == S_Z2), (r_z <= ofpg_pkg::QUARTER_FULL), "folded angle outside one quarter turn")

endmodule
